// File: rtl/png_scanline_unfilter_unit_macros.svh
// Assertion macros used by the PNG scanline unfilter top level.
`ifndef PNG_SCANLINE_UNFILTER_UNIT_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_UNIT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define PNGSU_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold at the same edge.
`define PNGSU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next edge.
`define PNGSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pngsu_pkg.sv
// Types, constants and helper functions of the PNG scanline unfilter.
package pngsu_pkg;

    localparam int BYTE_W      = 8;
    localparam int BPP_W       = 4;
    localparam int ROW_BYTES_W = 15;
    localparam int KIND_W      = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 15;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_BPP       = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES = 1'b1;

    localparam logic [KIND_W-1:0] FILT_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] FILT_SUB   = 3'd1;
    localparam logic [KIND_W-1:0] FILT_UP    = 3'd2;
    localparam logic [KIND_W-1:0] FILT_AVG   = 3'd3;
    localparam logic [KIND_W-1:0] FILT_PAETH = 3'd4;

    localparam logic [BYTE_W-1:0] FILT_TYPE_MAX = 8'd4;

    typedef struct packed {
        logic              bad;
        logic [KIND_W-1:0] kind;
        logic              first_row;
        logic              has_left;
        logic              row_last;
    } pngsu_ctrl_t;

    function automatic logic [BPP_W-1:0] clamp_bpp(
        input logic [BPP_W-1:0] value,
        input logic [BPP_W-1:0] max_value
    );
        logic [BPP_W-1:0] r;
        r = value;
        if (value == '0)
        begin
            r = BPP_W'(1);
        end
        else if (value > max_value)
        begin
            r = max_value;
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] paeth_pick(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [BYTE_W+1:0] p;
        logic signed [BYTE_W+1:0] pa;
        logic signed [BYTE_W+1:0] pb;
        logic signed [BYTE_W+1:0] pc;
        logic [BYTE_W-1:0]        r;
        p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
        pa = p - $signed({2'b00, a});
        pb = p - $signed({2'b00, b});
        pc = p - $signed({2'b00, c});
        if (pa < 0)
        begin
            pa = -pa;
        end
        if (pb < 0)
        begin
            pb = -pb;
        end
        if (pc < 0)
        begin
            pc = -pc;
        end
        if (pa <= pb && pa <= pc)
        begin
            r = a;
        end
        else if (pb <= pc)
        begin
            r = b;
        end
        else
        begin
            r = c;
        end
        return r;
    endfunction

endpackage

// File: rtl/pngsu_if.sv
// Handshake interfaces for the filtered input, raw output and register write channels.
interface pngsu_in_if;
    import pngsu_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              pass_start;
    modport source (output valid, output data_byte, output pass_start, input ready);
    modport sink   (input valid, input data_byte, input pass_start, output ready);
endinterface

interface pngsu_out_if;
    import pngsu_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              row_last;
    logic              bad_filter;
    modport source (output valid, output out_byte, output row_last, output bad_filter,
                    input ready);
    modport sink   (input valid, input out_byte, input row_last, input bad_filter,
                    output ready);
endinterface

interface pngsu_cfg_if;
    import pngsu_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/png_scanline_unfilter_unit.sv
// Top level of the PNG scanline unfilter: registers, front end, word queue and back end.
//
//   channel    role    words carried
//   filtered   sink    data_byte, pass_start
//   raw        source  out_byte, row_last, bad_filter
//   cfg        sink    index, data (register writes)
//
// One byte is accepted per cycle while the word queue is not full; a reconstructed word passes
// through the queue, the back-end stage register and the output register before it leaves.
// The prior-row RAM takes one read and one write per cycle, which sets that rate.
// Reset clears control state only; the prior-row RAM and histories need no clearing pass.
// A stall on raw fills the four-word queue before filtered.ready drops.
module png_scanline_unfilter_unit #(
    parameter int MAX_ROW_BYTES   = 16384,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    pngsu_in_if.sink     filtered,
    pngsu_out_if.source  raw,
    pngsu_cfg_if.sink    cfg
);
    import pngsu_pkg::*;
`include "png_scanline_unfilter_unit_macros.svh"

    localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int WORD_W = $bits(pngsu_ctrl_t) + BYTE_W + COL_W;

    logic [BPP_W-1:0]       bpp_reg;
    logic [BPP_W-1:0]       bpp_next;
    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [ROW_BYTES_W-1:0] row_bytes_next;

    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    pngsu_ctrl_t            push_ctrl;
    logic [BYTE_W-1:0]      push_byte;
    logic [COL_W-1:0]       push_col;
    logic [WORD_W-1:0]      head_word;
    pngsu_ctrl_t            head_ctrl;
    logic [BYTE_W-1:0]      head_byte;
    logic [COL_W-1:0]       head_col;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        bpp_next       = bpp_reg;
        row_bytes_next = row_bytes_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_BPP:       bpp_next       = cfg.data[BPP_W-1:0];
                REG_ROW_BYTES: row_bytes_next = cfg.data[ROW_BYTES_W-1:0];
                default:       bpp_next       = bpp_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg       <= BPP_W'(1);
            row_bytes_reg <= ROW_BYTES_W'(1);
        end
        else
        begin
            bpp_reg       <= bpp_next;
            row_bytes_reg <= row_bytes_next;
        end
    end

    pngsu_front #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .COL_W           (COL_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .filtered  (filtered),
        .bpp       (bpp_reg),
        .row_bytes (row_bytes_reg),
        .q_full    (q_full),
        .push      (q_push),
        .push_ctrl (push_ctrl),
        .push_byte (push_byte),
        .push_col  (push_col)
    );

    pngsu_fifo #(
        .WIDTH (WORD_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_ctrl, push_byte, push_col}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_word),
        .empty     (q_empty)
    );

    assign {head_ctrl, head_byte, head_col} = head_word;

    pngsu_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .COL_W           (COL_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .bpp       (bpp_reg),
        .q_valid   (!q_empty),
        .head_ctrl (head_ctrl),
        .head_byte (head_byte),
        .head_col  (head_col),
        .pop       (q_pop),
        .raw       (raw)
    );

    `PNGSU_ASSERT_IMP(a_push_room, q_push, !q_full, "word pushed into a full queue")
    `PNGSU_ASSERT_IMP(a_pop_data, q_pop, !q_empty, "word popped from an empty queue")
    `PNGSU_ASSERT_NEXT(a_queue_fill, q_push && !q_pop, !q_empty, "queue lost a pushed word")
    `PNGSU_ASSERT_IMP(a_error_word, raw.valid && raw.bad_filter,
        raw.out_byte == '0 && !raw.row_last, "error word carries data")

endmodule

// File: rtl/pngsu_fifo.sv
// Short word queue between the classifying front end and the reconstruction back end.
module pngsu_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    import pngsu_pkg::*;

    logic [WIDTH-1:0]  slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/pngsu_front.sv
// Front end: takes stream bytes, tracks row and pass position and classifies each byte.
module pngsu_front #(
    parameter int MAX_ROW_BYTES   = 16384,
    parameter int MAX_PIXEL_BYTES = 8,
    parameter int COL_W           = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    pngsu_in_if.sink                             filtered,
    input  logic [pngsu_pkg::BPP_W-1:0]          bpp,
    input  logic [pngsu_pkg::ROW_BYTES_W-1:0]    row_bytes,
    input  logic                                 q_full,
    output logic                                 push,
    output pngsu_pkg::pngsu_ctrl_t               push_ctrl,
    output logic [pngsu_pkg::BYTE_W-1:0]         push_byte,
    output logic [COL_W-1:0]                     push_col
);
    import pngsu_pkg::*;

    localparam int RLW = (COL_W + 1 > ROW_BYTES_W) ? COL_W + 1 : ROW_BYTES_W;
    localparam int HW  = (COL_W > BPP_W) ? COL_W : BPP_W;
    localparam logic [RLW-1:0]   ROW_MAX = RLW'(MAX_ROW_BYTES);
    localparam logic [BPP_W-1:0] BPP_MAX = BPP_W'(MAX_PIXEL_BYTES);

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [KIND_W-1:0] kind_reg;
    logic [KIND_W-1:0] kind_next;
    logic              first_row_reg;
    logic              first_row_next;
    logic              expect_type_reg;
    logic              expect_type_next;
    logic              err_hold_reg;
    logic              err_hold_next;

    logic              accept;
    logic [COL_W-1:0]  st_col;
    logic              st_first_row;
    logic              st_expect_type;
    logic              st_err_hold;
    logic [RLW-1:0]    rb_eff;
    logic [BPP_W-1:0]  bpp_eff;
    logic [RLW-1:0]    col_plus;
    logic              end_row;

    assign filtered.ready = !q_full;
    assign accept         = filtered.valid && filtered.ready;
    assign push_byte      = filtered.data_byte;
    assign push_col       = st_col;

    always_comb
    begin
        st_col         = filtered.pass_start ? '0 : col_reg;
        st_first_row   = filtered.pass_start ? 1'b1 : first_row_reg;
        st_expect_type = filtered.pass_start ? 1'b1 : expect_type_reg;
        st_err_hold    = filtered.pass_start ? 1'b0 : err_hold_reg;

        rb_eff = RLW'(row_bytes);
        if (rb_eff == '0)
        begin
            rb_eff = RLW'(1);
        end
        else if (rb_eff > ROW_MAX)
        begin
            rb_eff = ROW_MAX;
        end
        bpp_eff  = clamp_bpp(bpp, BPP_MAX);
        col_plus = RLW'(st_col) + RLW'(1);
        end_row  = (col_plus >= rb_eff);

        col_next         = col_reg;
        kind_next        = kind_reg;
        first_row_next   = first_row_reg;
        expect_type_next = expect_type_reg;
        err_hold_next    = err_hold_reg;

        push                = 1'b0;
        push_ctrl.bad       = 1'b0;
        push_ctrl.kind      = kind_reg;
        push_ctrl.first_row = st_first_row;
        push_ctrl.has_left  = (HW'(st_col) >= HW'(bpp_eff));
        push_ctrl.row_last  = end_row;

        if (accept)
        begin
            col_next         = st_col;
            first_row_next   = st_first_row;
            expect_type_next = st_expect_type;
            err_hold_next    = st_err_hold;
            if (!st_err_hold)
            begin
                if (st_expect_type)
                begin
                    if (filtered.data_byte > FILT_TYPE_MAX)
                    begin
                        err_hold_next = 1'b1;
                        push          = 1'b1;
                        push_ctrl.bad = 1'b1;
                    end
                    else
                    begin
                        kind_next        = filtered.data_byte[KIND_W-1:0];
                        expect_type_next = 1'b0;
                        col_next         = '0;
                    end
                end
                else
                begin
                    push = 1'b1;
                    if (end_row)
                    begin
                        col_next         = '0;
                        expect_type_next = 1'b1;
                        first_row_next   = 1'b0;
                    end
                    else
                    begin
                        col_next = col_plus[COL_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            kind_reg        <= FILT_NONE;
            first_row_reg   <= 1'b1;
            expect_type_reg <= 1'b1;
            err_hold_reg    <= 1'b0;
        end
        else
        begin
            col_reg         <= col_next;
            kind_reg        <= kind_next;
            first_row_reg   <= first_row_next;
            expect_type_reg <= expect_type_next;
            err_hold_reg    <= err_hold_next;
        end
    end

endmodule

// File: rtl/pngsu_back.sv
// Back end: reads the prior row, reconstructs each byte and holds the result word.
module pngsu_back #(
    parameter int MAX_ROW_BYTES   = 16384,
    parameter int MAX_PIXEL_BYTES = 8,
    parameter int COL_W           = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pngsu_pkg::BPP_W-1:0]   bpp,
    input  logic                          q_valid,
    input  pngsu_pkg::pngsu_ctrl_t        head_ctrl,
    input  logic [pngsu_pkg::BYTE_W-1:0]  head_byte,
    input  logic [COL_W-1:0]              head_col,
    output logic                          pop,
    pngsu_out_if.source                   raw
);
    import pngsu_pkg::*;

    localparam int PIX_IW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam logic [BPP_W-1:0] BPP_MAX = BPP_W'(MAX_PIXEL_BYTES);

    logic [BYTE_W-1:0] prior_mem [MAX_ROW_BYTES];
    logic [BYTE_W-1:0] rd_reg;
    logic [BYTE_W-1:0] left_hist_reg [MAX_PIXEL_BYTES];
    logic [BYTE_W-1:0] above_hist_reg [MAX_PIXEL_BYTES];

    logic              b_valid_reg;
    logic              b_valid_next;
    pngsu_ctrl_t       b_ctrl_reg;
    logic [BYTE_W-1:0] b_byte_reg;
    logic [COL_W-1:0]  b_col_reg;
    logic              fwd_hit_reg;
    logic [BYTE_W-1:0] fwd_val_reg;

    logic              o_valid_reg;
    logic              o_valid_next;
    logic [BYTE_W-1:0] o_byte_reg;
    logic              o_last_reg;
    logic              o_bad_reg;

    logic              o_free;
    logic              b_fire;
    logic              b_write;
    logic [BPP_W-1:0]  bpp_eff;
    logic [PIX_IW-1:0] hist_idx;
    logic [BYTE_W-1:0] above;
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] diag;
    logic [BYTE_W:0]   avg_sum;
    logic [BYTE_W-1:0] pred;
    logic [BYTE_W-1:0] val;

    assign o_free  = !o_valid_reg || raw.ready;
    assign b_fire  = b_valid_reg && o_free;
    assign b_write = b_fire && !b_ctrl_reg.bad;
    assign pop     = q_valid && (!b_valid_reg || b_fire);

    assign raw.valid      = o_valid_reg;
    assign raw.out_byte   = o_byte_reg;
    assign raw.row_last   = o_last_reg;
    assign raw.bad_filter = o_bad_reg;

    always_comb
    begin
        bpp_eff  = clamp_bpp(bpp, BPP_MAX);
        hist_idx = PIX_IW'(bpp_eff - BPP_W'(1));
        above    = '0;
        if (!b_ctrl_reg.first_row)
        begin
            above = fwd_hit_reg ? fwd_val_reg : rd_reg;
        end
        left = b_ctrl_reg.has_left ? left_hist_reg[hist_idx] : '0;
        diag = (!b_ctrl_reg.first_row && b_ctrl_reg.has_left) ? above_hist_reg[hist_idx] : '0;
        avg_sum = {1'b0, left} + {1'b0, above};
        unique case (b_ctrl_reg.kind)
            FILT_NONE:  pred = '0;
            FILT_SUB:   pred = left;
            FILT_UP:    pred = above;
            FILT_AVG:   pred = avg_sum[BYTE_W:1];
            FILT_PAETH: pred = paeth_pick(left, above, diag);
            default:    pred = '0;
        endcase
        val = b_byte_reg + pred;

        b_valid_next = b_valid_reg;
        if (pop)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_fire)
        begin
            b_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (b_fire)
        begin
            o_valid_next = 1'b1;
        end
        else if (raw.ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // The read at pop sees the old entry when the word ahead writes the same column.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_reg <= prior_mem[head_col];
        end
        if (b_write)
        begin
            prior_mem[b_col_reg] <= val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_ctrl_reg  <= head_ctrl;
            b_byte_reg  <= head_byte;
            b_col_reg   <= head_col;
            fwd_hit_reg <= b_write && (b_col_reg == head_col);
            fwd_val_reg <= val;
        end
        if (b_write)
        begin
            left_hist_reg[0]  <= val;
            above_hist_reg[0] <= above;
            for (int k = 1; k < MAX_PIXEL_BYTES; k++)
            begin
                left_hist_reg[k]  <= left_hist_reg[k-1];
                above_hist_reg[k] <= above_hist_reg[k-1];
            end
        end
        if (b_fire)
        begin
            o_byte_reg <= b_ctrl_reg.bad ? '0 : val;
            o_last_reg <= b_ctrl_reg.bad ? 1'b0 : b_ctrl_reg.row_last;
            o_bad_reg  <= b_ctrl_reg.bad;
        end
    end

endmodule

// File: tb/tb.sv
// Self-checking testbench of the PNG scanline unfilter with predictor, stimulus and handshake drivers.
module tb;
    import pngsu_pkg::*;

    localparam int MAX_ROW        = 16384;
    localparam int MAX_PIX        = 8;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_ROW_PART  = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              row_last;
        logic              bad_filter;
    } raw_word_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC,
        RX_BURSTY
    } rx_mode_t;

    class unfilter_scoreboard;
        logic [BYTE_W-1:0]      prior_row [MAX_ROW];
        logic [BYTE_W-1:0]      left_hist [MAX_PIX];
        logic [BYTE_W-1:0]      above_hist [MAX_PIX];
        int unsigned            column;
        logic [KIND_W-1:0]      kind;
        bit                     first_row;
        bit                     want_type;
        bit                     error_hold;
        logic [BPP_W-1:0]       bpp_reg;
        logic [ROW_BYTES_W-1:0] rb_reg;
        raw_word_t              expected_raw [$];
        int                     errors;

        function new();
            for (int k = 0; k < MAX_PIX; k++)
            begin
                left_hist[k]  = '0;
                above_hist[k] = '0;
            end
            column     = 0;
            kind       = FILT_NONE;
            first_row  = 1'b1;
            want_type  = 1'b1;
            error_hold = 1'b0;
            bpp_reg    = BPP_W'(1);
            rb_reg     = ROW_BYTES_W'(1);
            errors     = 0;
        endfunction

        function int unsigned pixel_stride();
            if (bpp_reg == 0)
            begin
                return 1;
            end
            if (bpp_reg > MAX_PIX)
            begin
                return MAX_PIX;
            end
            return bpp_reg;
        endfunction

        function int unsigned row_len();
            if (rb_reg == 0)
            begin
                return 1;
            end
            if (rb_reg > MAX_ROW)
            begin
                return MAX_ROW;
            end
            return rb_reg;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] reg_index, logic [CFG_DATA_W-1:0] value);
            if (reg_index == REG_BPP)
            begin
                bpp_reg = value[BPP_W-1:0];
            end
            else
            begin
                rb_reg = value[ROW_BYTES_W-1:0];
            end
        endfunction

        function logic [BYTE_W-1:0] paeth_choice(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b,
                                                 logic [BYTE_W-1:0] c);
            int p;
            int da;
            int db;
            int dc;
            p  = int'(a) + int'(b) - int'(c);
            da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
            db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
            dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
            if (da <= db && da <= dc)
            begin
                return a;
            end
            if (db <= dc)
            begin
                return b;
            end
            return c;
        endfunction

        function void take_byte(logic [BYTE_W-1:0] value, logic start);
            int unsigned       stride;
            int unsigned       col;
            logic [BYTE_W-1:0] lft;
            logic [BYTE_W-1:0] abv;
            logic [BYTE_W-1:0] dia;
            logic [BYTE_W-1:0] pred;
            logic [BYTE_W-1:0] rebuilt;
            raw_word_t         w;
            stride = pixel_stride();
            if (start)
            begin
                error_hold = 1'b0;
                first_row  = 1'b1;
                want_type  = 1'b1;
                column     = 0;
            end
            if (error_hold)
            begin
                return;
            end
            if (want_type)
            begin
                if (value > FILT_TYPE_MAX)
                begin
                    error_hold   = 1'b1;
                    w.out_byte   = '0;
                    w.row_last   = 1'b0;
                    w.bad_filter = 1'b1;
                    expected_raw.push_back(w);
                    return;
                end
                kind      = value[KIND_W-1:0];
                want_type = 1'b0;
                column    = 0;
                return;
            end
            col = (column >= MAX_ROW) ? MAX_ROW - 1 : column;
            lft = (col >= stride) ? left_hist[stride-1] : '0;
            abv = first_row ? '0 : prior_row[col];
            dia = (!first_row && col >= stride) ? above_hist[stride-1] : '0;
            case (kind)
                FILT_SUB:   pred = lft;
                FILT_UP:    pred = abv;
                FILT_AVG:   pred = BYTE_W'((int'(lft) + int'(abv)) >> 1);
                FILT_PAETH: pred = paeth_choice(lft, abv, dia);
                default:    pred = '0;
            endcase
            rebuilt = value + pred;
            for (int k = MAX_PIX - 1; k > 0; k--)
            begin
                left_hist[k]  = left_hist[k-1];
                above_hist[k] = above_hist[k-1];
            end
            left_hist[0]   = rebuilt;
            above_hist[0]  = abv;
            prior_row[col] = rebuilt;
            w.out_byte     = rebuilt;
            w.bad_filter   = 1'b0;
            if (col + 1 >= row_len())
            begin
                w.row_last = 1'b1;
                column     = 0;
                want_type  = 1'b1;
                first_row  = 1'b0;
            end
            else
            begin
                w.row_last = 1'b0;
                column     = col + 1;
            end
            expected_raw.push_back(w);
        endfunction

        function void check_word(logic [BYTE_W-1:0] ob, logic rl, logic bf);
            raw_word_t w;
            if (expected_raw.size() == 0)
            begin
                $display("%0t: unexpected word out_byte=%02h row_last=%0b bad_filter=%0b",
                         $time, ob, rl, bf);
                errors++;
                return;
            end
            w = expected_raw.pop_front();
            if (ob !== w.out_byte)
            begin
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, w.out_byte, ob);
                errors++;
            end
            if (rl !== w.row_last)
            begin
                $display("%0t: row_last mismatch: expected %0b, actual %0b",
                         $time, w.row_last, rl);
                errors++;
            end
            if (bf !== w.bad_filter)
            begin
                $display("%0t: bad_filter mismatch: expected %0b, actual %0b",
                         $time, w.bad_filter, bf);
                errors++;
            end
        endfunction

        function int words_pending();
            return expected_raw.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic rx_ready = 1'b0;

    rx_mode_t    rx_mode = RX_FREE;
    logic [15:0] rx_cycle = '0;
    int unsigned rx_stall = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned random_count = 0;
    bit          large_done = 1'b0;

    logic [BYTE_W-1:0] corner_bytes [4] = '{8'hFF, 8'h00, 8'h80, 8'h7F};

    unfilter_scoreboard scoreboard;

    pngsu_in_if  filtered ();
    pngsu_out_if raw ();
    pngsu_cfg_if cfg ();

    assign raw.ready = rx_ready;

    png_scanline_unfilter_unit #(
        .MAX_ROW_BYTES   (MAX_ROW),
        .MAX_PIXEL_BYTES (MAX_PIX)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .filtered (filtered),
        .raw      (raw),
        .cfg      (cfg)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1'b1;
        if (rx_cycle[6:0] == 7'd0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        end
        if (rx_stall != 0)
        begin
            rx_stall <= rx_stall - 1;
            rx_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_FREE:     rx_ready <= 1'b1;
                RX_RANDOM:   rx_ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: rx_ready <= (rx_cycle[2:0] < 3'd5);
                default:
                begin
                    rx_ready <= 1'b1;
                    if ($urandom_range(0, 31) == 0)
                    begin
                        rx_stall <= $urandom_range(4, 40);
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && raw.valid && raw.ready)
        begin
            scoreboard.check_word(raw.out_byte, raw.row_last, raw.bad_filter);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((filtered.valid && filtered.ready) || (raw.valid && raw.ready) ||
                (cfg.valid && cfg.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic [BYTE_W-1:0] byte_value();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic start);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            if (gap != 0)
            begin
                filtered.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        filtered.valid      <= 1'b1;
        filtered.data_byte  <= value;
        filtered.pass_start <= start;
        do
        begin
            @(posedge clk);
        end
        while (!filtered.ready);
        scoreboard.take_byte(value, start);
    endtask

    task automatic wait_idle();
        filtered.valid <= 1'b0;
        while (scoreboard.words_pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= reg_index;
        cfg.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        scoreboard.write_reg(reg_index, value);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random_phase(input int unsigned budget);
        int unsigned       sent;
        int unsigned       noise;
        bit                start;
        bit                cut;
        logic [BYTE_W-1:0] ftype;
        sent = 0;
        while (sent < budget)
        begin
            start = 1'b1;
            while (1)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    ftype = BYTE_W'($urandom_range(5, 255));
                end
                else
                begin
                    ftype = BYTE_W'($urandom_range(0, 4));
                end
                send_byte(ftype, start);
                start = 1'b0;
                sent++;
                if (ftype > FILT_TYPE_MAX)
                begin
                    noise = $urandom_range(0, 3);
                    repeat (noise) send_byte(byte_value(), 1'b0);
                    break;
                end
                cut = 1'b0;
                for (int k = 0; k < scoreboard.row_len(); k++)
                begin
                    if ($urandom_range(0, 199) == 0)
                    begin
                        cut = 1'b1;
                        break;
                    end
                    send_byte(byte_value(), 1'b0);
                    sent++;
                end
                if (cut || sent >= budget || $urandom_range(0, 5) == 0)
                begin
                    break;
                end
            end
        end
        random_count += sent;
    endtask

    initial
    begin
        scoreboard          = new();
        filtered.valid      = 1'b0;
        filtered.data_byte  = '0;
        filtered.pass_start = 1'b0;
        cfg.valid           = 1'b0;
        cfg.index           = REG_BPP;
        cfg.data            = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_BPP, CFG_DATA_W'(2));
        write_reg(REG_ROW_BYTES, CFG_DATA_W'(3));
        for (int f = 0; f <= 4; f++)
        begin
            send_byte(BYTE_W'(f), f == 0);
            for (int k = 0; k < 3; k++)
            begin
                send_byte(corner_bytes[(k + f) % 4], 1'b0);
            end
        end
        send_byte(FILT_TYPE_MAX + 1'b1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(BYTE_W'(FILT_PAETH), 1'b1);
        for (int k = 0; k < 3; k++)
        begin
            send_byte(corner_bytes[k], 1'b0);
        end

        // A row cut short by a smaller row length, then a row reading only what that row wrote.
        wait_idle();
        write_reg(REG_BPP, CFG_DATA_W'(15));
        write_reg(REG_ROW_BYTES, CFG_DATA_W'(6));
        send_byte(BYTE_W'(FILT_SUB), 1'b1);
        send_byte(8'h9C, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE7, 1'b0);
        wait_idle();
        write_reg(REG_ROW_BYTES, CFG_DATA_W'(2));
        write_reg(REG_BPP, 15'h7FF1);
        send_byte(8'h3A, 1'b0);
        send_byte(BYTE_W'(FILT_UP), 1'b0);
        send_byte(8'hC5, 1'b0);
        send_byte(8'h5D, 1'b0);
        wait_idle();
        write_reg(REG_ROW_BYTES, CFG_DATA_W'(0));
        write_reg(REG_BPP, CFG_DATA_W'(0));
        send_byte(BYTE_W'(FILT_PAETH), 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(BYTE_W'(FILT_AVG), 1'b0);
        send_byte(8'h0F, 1'b0);

        while (random_count < RANDOM_ITEMS)
        begin
            wait_idle();
            if (!large_done && random_count >= RANDOM_ITEMS / 2)
            begin
                large_done = 1'b1;
                // Very long rows, each pass cut short by the next pass start.
                write_reg(REG_BPP, {11'($urandom), 4'($urandom_range(1, 8))});
                write_reg(REG_ROW_BYTES, 15'h7FFF);
                send_byte(BYTE_W'($urandom_range(0, 4)), 1'b1);
                repeat (LONG_ROW_PART) send_byte(byte_value(), 1'b0);
                send_byte(BYTE_W'(FILT_PAETH), 1'b1);
                repeat (LONG_ROW_PART) send_byte(byte_value(), 1'b0);
                wait_idle();
            end
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_BPP, {11'($urandom),
                          4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 8))});
            end
            case ($urandom_range(0, 9))
                0:       write_reg(REG_ROW_BYTES, CFG_DATA_W'(0));
                1:       write_reg(REG_ROW_BYTES, CFG_DATA_W'($urandom_range(41, 100)));
                2, 3:    write_reg(REG_ROW_BYTES, CFG_DATA_W'($urandom_range(13, 40)));
                default: write_reg(REG_ROW_BYTES, CFG_DATA_W'($urandom_range(1, 12)));
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_BPP, {11'($urandom),
                          4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 8))});
            end
            run_random_phase($urandom_range(30, 120));
        end

        filtered.valid <= 1'b0;
        while (scoreboard.words_pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (scoreboard.errors == 0 && scoreboard.words_pending() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
